### hdl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

	// Largest value of a 63-bit length or offset
	localparam logic [62:0] MAX63 = {63{1'b1}};

	// Result kinds
	localparam logic [1:0] KIND_EMPTY   = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_SHORT   = 2'd2;

	// One result of the parser
	typedef struct packed {
		logic        emit;
		logic [1:0]  kind;
		logic [7:0]  byte_value;
		logic [62:0] byte_offset;
		logic        fin_bit;
		logic [2:0]  reserved_bits;
		logic [3:0]  frame_opcode;
		logic        masked;
		logic [62:0] frame_length;
		logic [62:0] message_length;
		logic        frame_done;
	} wsd_res_t;

endpackage

`default_nettype wire

### hdl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header decoder and payload unmasker: holds the parse state and works
// out the result of one byte combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parser
	import wsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic       buffer_end,
	output wsd_res_t        res
);

	// Parse phases
	localparam logic [2:0] PH_HDR0 = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_KEY  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_DROP = 3'd5;

	// Saturating sum of a 63-bit base and a 64-bit length
	function automatic logic [62:0] sat_add(input logic [62:0] a, input logic [63:0] b);
		logic [62:0] bc;
		logic [63:0] sum;
		bc  = b[63] ? MAX63 : b[62:0];
		sum = {1'b0, a} + {1'b0, bc};
		return sum[63] ? MAX63 : sum[62:0];
	endfunction

	logic [2:0]  phase_q, phase_d;
	logic [3:0]  hcnt_q, hcnt_d;
	logic [8:0]  flags_q, flags_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [63:0] rem_q, rem_d;
	logic [1:0]  kidx_q, kidx_d;
	logic [62:0] off_q, off_d;
	logic [62:0] stored_q, stored_d;
	logic [62:0] base_q, base_d;

	logic        emit, chk, err, done;
	logic [1:0]  kind;
	logic [7:0]  value;
	logic [62:0] offset, msglen, final_len;
	logic [7:0]  kb;

	// Pick the key byte, first received byte first
	always_comb begin
		case (kidx_q)
			2'd0:    kb = key_q[31:24];
			2'd1:    kb = key_q[23:16];
			2'd2:    kb = key_q[15:8];
			default: kb = key_q[7:0];
		endcase
	end

	assign final_len = sat_add(base_q, len_q);

	// Next state and result of one byte
	always_comb begin
		phase_d  = phase_q;
		hcnt_d   = hcnt_q;
		flags_d  = flags_q;
		len_d    = len_q;
		key_d    = key_q;
		rem_d    = rem_q;
		kidx_d   = kidx_q;
		off_d    = off_q;
		stored_d = stored_q;
		base_d   = base_q;
		emit     = 1'b0;
		chk      = 1'b1;
		kind     = KIND_EMPTY;
		value    = '0;
		offset   = '0;
		msglen   = '0;
		done     = 1'b0;

		unique case (phase_q)
			PH_HDR1: begin
				flags_d[8] = flags_q[8] | data_byte[7];
				if (data_byte[6:0] <= 7'd125) begin
					len_d = {57'd0, data_byte[6:0]};
					rem_d = len_d;
					if (flags_d[8]) begin
						phase_d = PH_KEY;
						hcnt_d  = 4'd4;
					end else if (data_byte[6:0] == 7'd0) begin
						// empty frame: message length stays at the base
						stored_d = base_q;
						emit     = 1'b1;
						kind     = KIND_EMPTY;
						offset   = base_q;
						msglen   = base_q;
						done     = 1'b1;
						phase_d  = buffer_end ? PH_HDR0 : PH_DROP;
					end else begin
						phase_d = PH_DATA;
					end
				end else begin
					phase_d = PH_EXT;
					hcnt_d  = (data_byte[6:0] == 7'd126) ? 4'd2 : 4'd8;
				end
			end
			PH_EXT: begin
				len_d  = {len_q[55:0], data_byte};
				rem_d  = len_d;
				hcnt_d = hcnt_q - 4'd1;
				if (hcnt_d == 4'd0) begin
					if (flags_q[8]) begin
						phase_d = PH_KEY;
						hcnt_d  = 4'd4;
					end else if (len_d == 64'd0) begin
						stored_d = base_q;
						emit     = 1'b1;
						kind     = KIND_EMPTY;
						offset   = base_q;
						msglen   = base_q;
						done     = 1'b1;
						phase_d  = buffer_end ? PH_HDR0 : PH_DROP;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_KEY: begin
				key_d  = {key_q[23:0], data_byte};
				hcnt_d = hcnt_q - 4'd1;
				if (hcnt_d == 4'd0) begin
					if (len_q == 64'd0) begin
						stored_d = base_q;
						emit     = 1'b1;
						kind     = KIND_EMPTY;
						offset   = base_q;
						msglen   = base_q;
						done     = 1'b1;
						phase_d  = buffer_end ? PH_HDR0 : PH_DROP;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (rem_q == 64'd1) begin
					// last payload byte completes the frame
					chk      = 1'b0;
					stored_d = final_len;
					emit     = 1'b1;
					kind     = KIND_PAYLOAD;
					value    = data_byte ^ kb;
					offset   = off_q;
					msglen   = final_len;
					done     = 1'b1;
					phase_d  = buffer_end ? PH_HDR0 : PH_DROP;
				end else if (!buffer_end) begin
					chk    = 1'b0;
					emit   = 1'b1;
					kind   = KIND_PAYLOAD;
					value  = data_byte ^ kb;
					offset = off_q;
					msglen = final_len;
					rem_d  = rem_q - 64'd1;
					kidx_d = kidx_q + 2'd1;
					off_d  = (off_q == MAX63) ? MAX63 : off_q + 63'd1;
				end
			end
			PH_DROP: begin
				chk = 1'b0;
				if (buffer_end) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				// first header byte; continuation frames carry on the message
				flags_d = {1'b0, data_byte};
				len_d   = '0;
				key_d   = '0;
				rem_d   = '0;
				kidx_d  = '0;
				hcnt_d  = '0;
				base_d  = (data_byte[3:0] == 4'd0) ? stored_q : '0;
				off_d   = base_d;
				phase_d = PH_HDR1;
			end
		endcase

		// buffer ended before the frame was complete
		err = chk && !emit && buffer_end;
		if (err) begin
			emit    = 1'b1;
			kind    = KIND_SHORT;
			value   = '0;
			offset  = '0;
			msglen  = stored_q;
			done    = 1'b0;
			phase_d = PH_HDR0;
		end
	end

	// Assemble the result from the updated header fields
	always_comb begin
		res.emit           = emit;
		res.kind           = kind;
		res.byte_value     = value;
		res.byte_offset    = offset;
		res.fin_bit        = flags_d[7];
		res.reserved_bits  = flags_d[6:4];
		res.frame_opcode   = flags_d[3:0];
		res.masked         = flags_d[8];
		res.frame_length   = len_d[63] ? MAX63 : len_d[62:0];
		res.message_length = msglen;
		res.frame_done     = done;
	end

	// Advance the parse state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			hcnt_q   <= '0;
			flags_q  <= '0;
			len_q    <= '0;
			key_q    <= '0;
			rem_q    <= '0;
			kidx_q   <= '0;
			off_q    <= '0;
			stored_q <= '0;
			base_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			hcnt_q   <= hcnt_d;
			flags_q  <= flags_d;
			len_q    <= len_d;
			key_q    <= key_d;
			rem_q    <= rem_d;
			kidx_q   <= kidx_d;
			off_q    <= off_d;
			stored_q <= stored_d;
			base_q   <= base_d;
		end
	end

endmodule

`default_nettype wire

### hdl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Decodes WebSocket frames from a byte stream and streams unmasked payload.
// ----------------------------------------------------------------------------
// Usage:
// Input channel s_axis_*: one received byte per transaction in tdata, with
// tlast high on the last byte of a receive buffer.
// Output channel m_axis_*: at most one result per input byte. tuser carries
// the kind (empty frame done, payload byte, buffer too short), tlast marks the
// result that completes a frame, tdata carries the byte, its offset within the
// message and the decoded header fields.
// Path: an accepted byte is held in the input register, parsed by the
// combinational parse step and its result taken into the result register.
// Throughput: one byte per clock cycle while the receiver does not stall, set
// by the combinational parse step between the input and result registers.
// Header bytes that neither complete an empty frame nor end a buffer too early,
// trailing bytes after a complete frame and dropped bytes of a buffer give no result.
// Reset clears the parse state and the stored message length; the block waits
// for the first header byte. When the receiver stalls, the result is held and
// one more byte is buffered before s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer
	import wsd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,  // [7:0] data_byte
	input  wire logic         s_axis_tlast,  // buffer_end
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [7:0] byte_value, [70:8] byte_offset, [71] fin_bit, [74:72] reserved_bits,
	// [78:75] frame_opcode, [79] masked, [142:80] frame_length,
	// [205:143] message_length, [207:206] zero
	output logic [207:0]      m_axis_tdata,
	output logic [1:0]        m_axis_tuser,  // [1:0] kind
	output logic              m_axis_tlast   // frame_done
);

	logic       in_valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       out_valid_s2;
	wsd_res_t   res;
	wsd_res_t   res_s2;
	logic       adv;
	logic       step;

	assign adv           = !out_valid_s2 || m_axis_tready;
	assign step          = in_valid_s1 && adv;
	assign s_axis_tready = !in_valid_s1 || adv;

	// Hold the accepted byte for the parse step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	wsd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (byte_s1),
		.buffer_end (end_s1),
		.res        (res)
	);

	// Register the result; hold it while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= step && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tlast  = res_s2.frame_done;
	assign m_axis_tdata  = {2'b00,
	                        res_s2.message_length,
	                        res_s2.frame_length,
	                        res_s2.masked,
	                        res_s2.frame_opcode,
	                        res_s2.reserved_bits,
	                        res_s2.fin_bit,
	                        res_s2.byte_offset,
	                        res_s2.byte_value};

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Byte-stream check of the WebSocket frame deframer. A short scripted run
// covers the corner cases of the frame header, then random frames (mostly
// well formed, some cut short, some noise) are sent under several patterns
// of sender idling and receiver back-pressure. Every output transaction is
// compared field by field with a cycle-free model of the parser.
// ----------------------------------------------------------------------------

module testbench
	import wsd_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_BYTES   = 1000;
	localparam int DRAIN_CYCLES   = 20;

	typedef enum logic [2:0] {
		WAIT_FLAGS, WAIT_LEN, EXT_LEN, MASK_KEY, PAYLOAD, DISCARD
	} parse_state_t;

	// One expected output transaction
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  value;
		logic [62:0] offset;
		logic        fin;
		logic [2:0]  rsv;
		logic [3:0]  opcode;
		logic        masked;
		logic [62:0] flen;
		logic [62:0] mlen;
		logic        done;
	} deframe_res_t;

	// One input byte; typed rows override kind, value, offset, length and done
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        typed;
		logic [1:0]  kind;
		logic [7:0]  value;
		logic [62:0] offset;
		logic [62:0] mlen;
		logic        done;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [207:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	// Parser state of the model
	parse_state_t phase = WAIT_FLAGS;
	logic [3:0]   hdr_left = '0;
	logic [8:0]   hdr_flags = '0;
	logic [63:0]  frame_len = '0;
	logic [31:0]  mask_key = '0;
	logic [63:0]  pay_idx = '0;
	logic [62:0]  msg_len = '0;
	logic [62:0]  base_off = '0;

	deframe_res_t pending_results[$];
	stim_row_t    wire_q[$];
	int           mismatches = 0;
	int           quiet_cycles = 0;
	int           idle_pct = 0;
	int           stall_pct = 0;
	int           frame_bytes = 0;
	int           idle_table [4] = '{0, 62, 0, 14};
	int           stall_table [4] = '{0, 0, 62, 14};

	// Scripted corner cases: empty frame, trailing bytes, masked payload,
	// 16-bit and 64-bit lengths, saturation, buffer ending too early
	stim_row_t script [29] = '{
		'{8'h81, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'h00, 1'b0, 1'b1, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b1},
		'{8'h00, 1'b1, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'h02, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'h82, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'hA5, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'h5A, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'h3C, 1'b1, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'h70, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'h7F, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'h5A, 1'b0, 1'b1, KIND_PAYLOAD, 8'h5A, 63'd2, MAX63, 1'b0},
		'{8'h00, 1'b1, 1'b1, KIND_SHORT, 8'h00, 63'd0, 63'd2, 1'b0},
		'{8'h80, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'h7E, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'h01, 1'b0, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0},
		'{8'hAB, 1'b1, 1'b0, KIND_EMPTY, 8'h00, 63'd0, 63'd0, 1'b0}
	};

	websocket_frame_deframer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sum of two lengths, each clamped, saturating at the 63-bit maximum
	function automatic logic [62:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ca;
		logic [63:0] cb;
		logic [63:0] sum;
		ca = (a > {1'b0, MAX63}) ? {1'b0, MAX63} : a;
		cb = (b > {1'b0, MAX63}) ? {1'b0, MAX63} : b;
		sum = ca + cb;
		return (sum > {1'b0, MAX63}) ? MAX63 : sum[62:0];
	endfunction

	function automatic deframe_res_t make_result(input logic [1:0] kind,
			input logic [7:0] value, input logic [62:0] offset,
			input logic [62:0] mlen, input logic done);
		deframe_res_t r;
		r.kind   = kind;
		r.value  = value;
		r.offset = offset;
		r.fin    = hdr_flags[7];
		r.rsv    = hdr_flags[6:4];
		r.opcode = hdr_flags[3:0];
		r.masked = hdr_flags[8];
		r.flen   = (frame_len > {1'b0, MAX63}) ? MAX63 : frame_len[62:0];
		r.mlen   = mlen;
		r.done   = done;
		return r;
	endfunction

	// Complete a frame with no payload
	task automatic close_empty(input bit buf_end, output bit got, output deframe_res_t r);
		msg_len = add_sat({1'b0, base_off}, frame_len);
		r = make_result(KIND_EMPTY, 8'h00, base_off, msg_len, 1'b1);
		phase = buf_end ? WAIT_FLAGS : DISCARD;
		got = 1'b1;
	endtask

	// Length known: go on to the key, the payload, or finish an empty frame
	task automatic finish_length(input bit buf_end, output bit got, output deframe_res_t r);
		got = 1'b0;
		r = '0;
		if (hdr_flags[8]) begin
			phase = MASK_KEY;
			hdr_left = 4'd4;
		end else if (frame_len == 64'd0) begin
			close_empty(buf_end, got, r);
		end else begin
			phase = PAYLOAD;
		end
	endtask

	// Advance the model by one accepted byte
	task automatic parse_byte(input logic [7:0] b, input bit buf_end,
			output bit got, output deframe_res_t r);
		logic [1:0]  idx;
		logic [7:0]  kb;
		logic [62:0] off;
		got = 1'b0;
		r = '0;
		case (phase)
			WAIT_LEN: begin
				if (b[7])
					hdr_flags[8] = 1'b1;
				if (b[6:0] <= 7'd125) begin
					frame_len = {57'd0, b[6:0]};
					finish_length(buf_end, got, r);
				end else begin
					phase = EXT_LEN;
					hdr_left = (b[6:0] == 7'd126) ? 4'd2 : 4'd8;
				end
			end
			EXT_LEN: begin
				frame_len = {frame_len[55:0], b};
				hdr_left = hdr_left - 4'd1;
				if (hdr_left == 4'd0)
					finish_length(buf_end, got, r);
			end
			MASK_KEY: begin
				mask_key = {mask_key[23:0], b};
				hdr_left = hdr_left - 4'd1;
				if (hdr_left == 4'd0) begin
					if (frame_len == 64'd0)
						close_empty(buf_end, got, r);
					else
						phase = PAYLOAD;
				end
			end
			PAYLOAD: begin
				idx = pay_idx[1:0];
				kb = mask_key[8 * (3 - idx) +: 8];
				off = add_sat({1'b0, base_off}, pay_idx);
				if (pay_idx + 64'd1 == frame_len) begin
					msg_len = add_sat({1'b0, base_off}, frame_len);
					r = make_result(KIND_PAYLOAD, b ^ kb, off, msg_len, 1'b1);
					phase = buf_end ? WAIT_FLAGS : DISCARD;
					got = 1'b1;
				end else if (!buf_end) begin
					r = make_result(KIND_PAYLOAD, b ^ kb, off,
						add_sat({1'b0, base_off}, frame_len), 1'b0);
					pay_idx = pay_idx + 64'd1;
					got = 1'b1;
				end
			end
			DISCARD: begin
				// drop trailing bytes silently until the buffer ends
				if (buf_end)
					phase = WAIT_FLAGS;
				return;
			end
			default: begin
				hdr_flags = {1'b0, b};
				frame_len = '0;
				mask_key = '0;
				pay_idx = '0;
				hdr_left = '0;
				base_off = (b[3:0] == 4'h0) ? msg_len : '0;
				phase = WAIT_LEN;
			end
		endcase
		// buffer ended before the frame was complete
		if (!got && buf_end) begin
			r = make_result(KIND_SHORT, 8'h00, 63'd0, msg_len, 1'b0);
			phase = WAIT_FLAGS;
			got = 1'b1;
		end
	endtask

	// Offer one byte, wait for the transaction and record what it should give
	task automatic send_byte(input stim_row_t row);
		bit           got;
		deframe_res_t r;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= row.data;
		s_tlast <= row.last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		parse_byte(row.data, row.last, got, r);
		if (row.typed) begin
			r.kind = row.kind;
			r.value = row.value;
			r.offset = row.offset;
			r.mlen = row.mlen;
			r.done = row.done;
			got = 1'b1;
		end
		if (got)
			pending_results.push_back(r);
		@(negedge clk);
	endtask

	// Build one random buffer: a frame (possibly cut short) or plain noise
	task automatic queue_frame();
		stim_row_t   row;
		logic [7:0]  fb[$];
		logic [7:0]  first;
		logic [63:0] len64;
		int          plen;
		int          pick;
		int          cut;
		int          trail;
		int          i;
		bit          masked;
		bit          huge;
		row = '0;
		pick = $urandom_range(99);
		if (pick < 10) begin
			repeat ($urandom_range(6, 1)) begin
				row.data = 8'($urandom);
				row.last = ($urandom_range(3) == 0);
				wire_q.push_back(row);
			end
			return;
		end
		first = 8'($urandom);
		if ($urandom_range(2) == 0)
			first[3:0] = 4'h0;
		masked = 1'($urandom_range(1));
		huge = ($urandom_range(19) == 0);
		pick = $urandom_range(99);
		if (pick < 15)
			plen = 0;
		else if (pick < 90)
			plen = $urandom_range(12, 1);
		else
			plen = $urandom_range(400, 126);
		len64 = 64'(plen);
		if (huge)
			len64 = {32'($urandom), 32'($urandom)} | 64'h1_0000_0000;
		fb.push_back(first);
		// length in 7 bits, or as a 16-bit or 64-bit extension
		pick = $urandom_range(9);
		if (!huge && plen <= 125 && pick < 7) begin
			fb.push_back({masked, 7'(plen)});
		end else if (!huge && pick < 9) begin
			fb.push_back({masked, 7'd126});
			fb.push_back(len64[15:8]);
			fb.push_back(len64[7:0]);
		end else begin
			fb.push_back({masked, 7'd127});
			for (i = 7; i >= 0; i--)
				fb.push_back(len64[8 * i +: 8]);
		end
		if (masked)
			repeat (4) fb.push_back(8'($urandom));
		repeat (huge ? $urandom_range(8, 1) : plen)
			fb.push_back(8'($urandom));
		// cut short, or complete with some trailing bytes
		if (huge || $urandom_range(9) == 0) begin
			cut = huge ? $urandom_range(fb.size() - 1) : $urandom_range(fb.size() - 2);
			trail = 0;
		end else begin
			cut = fb.size() - 1;
			trail = $urandom_range(3);
		end
		frame_bytes += cut + 1;
		for (i = 0; i <= cut; i++) begin
			row.data = fb[i];
			row.last = (i == cut) && (trail == 0);
			wire_q.push_back(row);
		end
		for (i = 1; i <= trail; i++) begin
			row.data = 8'($urandom);
			row.last = (i == trail);
			wire_q.push_back(row);
		end
	endtask

	task automatic compare_field(input string name, input logic [62:0] want,
			input logic [62:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Receiver back-pressure
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// Compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		deframe_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("output transaction with no expectation waiting");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("kind", 63'(want.kind), 63'(m_tuser));
				compare_field("byte_value", 63'(want.value), 63'(m_tdata[7:0]));
				compare_field("byte_offset", want.offset, m_tdata[70:8]);
				compare_field("fin_bit", 63'(want.fin), 63'(m_tdata[71]));
				compare_field("reserved_bits", 63'(want.rsv), 63'(m_tdata[74:72]));
				compare_field("frame_opcode", 63'(want.opcode), 63'(m_tdata[78:75]));
				compare_field("masked", 63'(want.masked), 63'(m_tdata[79]));
				compare_field("frame_length", want.flen, m_tdata[142:80]);
				compare_field("message_length", want.mlen, m_tdata[205:143]);
				compare_field("frame_done", 63'(want.done), 63'(m_tlast));
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int sel;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// scripted part, no idling
		foreach (script[k])
			send_byte(script[k]);

		// random part, one idling pattern per quarter
		while (frame_bytes < RANDOM_BYTES) begin
			sel = frame_bytes * 4 / RANDOM_BYTES;
			if (sel > 3)
				sel = 3;
			idle_pct = idle_table[sel];
			stall_pct = stall_table[sel];
			queue_frame();
			while (wire_q.size() != 0)
				send_byte(wire_q.pop_front());
		end
		s_tvalid <= 1'b0;

		// drain outstanding results, then let the pipeline settle
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
